// ===== hdl/fec_pkg.sv =====
// Shared types and constants for the flit ejection checker.
// Flit and result payload structs, flit kinds, status codes, register indexes.
// No dependencies.
`default_nettype none

package fec_pkg;

    localparam int COORD_BITS     = 3;
    localparam int SRC_BITS       = 3 * COORD_BITS;
    localparam int PKT_CNT_BITS   = 16;
    localparam int FIDX_BITS      = 4;
    localparam int FPP_BITS       = 5;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 5;
    localparam int DEF_PORTS      = 8;
    localparam int DEF_MAX_FLITS  = 16;

    typedef enum logic [1:0] {
        KIND_HEAD   = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_TAIL   = 2'd2,
        KIND_SINGLE = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_START_BUSY   = 4'd1,
        ST_CONT_IDLE    = 4'd2,
        ST_BAD_DEST     = 4'd3,
        ST_SRC_MISMATCH = 4'd4,
        ST_NOT_SENT     = 4'd5,
        ST_INCOMPLETE   = 4'd6,
        ST_BAD_INDEX    = 4'd7,
        ST_SINGLE_WARN  = 4'd8
    } t_status;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_Z = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FPP    = 2'd3;

    typedef struct packed {
        logic [2:0]            port;
        t_kind                 kind;
        logic [COORD_BITS-1:0] src_x;
        logic [COORD_BITS-1:0] src_y;
        logic [COORD_BITS-1:0] src_z;
        logic [COORD_BITS-1:0] dst_x;
        logic [COORD_BITS-1:0] dst_y;
        logic [COORD_BITS-1:0] dst_z;
        logic [FIDX_BITS-1:0]  flit_index;
        logic [9:0]            packet_number;
        logic                  was_sent;
        logic [31:0]           now;
    } t_flit_in;

    typedef struct packed {
        t_status               status;
        logic                  packet_done;
        logic [9:0]            done_packet;
        logic [COORD_BITS-1:0] done_src_x;
        logic [COORD_BITS-1:0] done_src_y;
        logic [COORD_BITS-1:0] done_src_z;
        logic [31:0]           recv_time;
        logic [PKT_CNT_BITS-1:0] port_packets;
    } t_result;

    typedef struct packed {
        logic [COORD_BITS-1:0] node_x;
        logic [COORD_BITS-1:0] node_y;
        logic [COORD_BITS-1:0] node_z;
        logic [FPP_BITS-1:0]   flits_per_packet;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/fec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read data updates only on a read enable. No dependencies.
`default_nettype none

module fec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fec_check.sv =====
// Wormhole rule checks for one flit against its port's state; builds the
// result and the port's next state. Depends on fec_pkg.
`default_nettype none

module fec_check
    import fec_pkg::*;
#(
    parameter int MAX_FLITS = DEF_MAX_FLITS,
    parameter int IW        = $clog2(MAX_FLITS)
) (
    input  wire t_flit_in                  i_flit,
    input  wire t_cfg                      i_cfg,
    input  wire logic                      i_rcv,
    input  wire logic [IW-1:0]             i_exp,
    input  wire logic [SRC_BITS-1:0]       i_hsrc,
    input  wire logic [PKT_CNT_BITS-1:0]   i_pcnt,
    output t_result                        o_res,
    output logic                           o_rcv,
    output logic      [IW-1:0]             o_exp,
    output logic      [SRC_BITS-1:0]       o_hsrc,
    output logic      [PKT_CNT_BITS-1:0]   o_pcnt
);

    localparam int CW = (IW + 1 > FPP_BITS) ? IW + 1 : FPP_BITS;
    localparam int XW = (IW > FIDX_BITS) ? IW : FIDX_BITS;

    logic                start;
    logic                dst_ok;
    logic                src_ok;
    logic [SRC_BITS-1:0] src;
    logic [IW:0]         exp_inc;
    logic [IW-1:0]       exp_wrap;
    logic                size_ok;
    logic                idx_ok;
    t_status             status;
    logic                done;

    assign start   = (i_flit.kind == KIND_HEAD) || (i_flit.kind == KIND_SINGLE);
    assign dst_ok  = (i_flit.dst_x == i_cfg.node_x) && (i_flit.dst_y == i_cfg.node_y)
                  && (i_flit.dst_z == i_cfg.node_z);
    assign src     = {i_flit.src_z, i_flit.src_y, i_flit.src_x};
    assign src_ok  = (src == i_hsrc);
    assign exp_inc = {1'b0, i_exp} + (IW + 1)'(1);
    assign exp_wrap = (exp_inc == (IW + 1)'(MAX_FLITS)) ? '0 : exp_inc[IW-1:0];
    // tail compares the unwrapped count against the size as written
    assign size_ok = (CW'(exp_inc) == CW'(i_cfg.flits_per_packet));
    assign idx_ok  = (i_flit.kind == KIND_SINGLE) ? (i_flit.flit_index == '0)
                   : (XW'(i_flit.flit_index) == XW'(i_exp));

    always_comb begin
        status = ST_OK;
        if (start ? i_rcv : !i_rcv) begin
            status = start ? ST_START_BUSY : ST_CONT_IDLE;
        end else if (!dst_ok) begin
            status = ST_BAD_DEST;
        end else if (!start && !src_ok) begin
            status = ST_SRC_MISMATCH;
        end else if (!i_flit.was_sent) begin
            status = ST_NOT_SENT;
        end else if (i_flit.kind == KIND_TAIL && !size_ok) begin
            status = ST_INCOMPLETE;
        end else if (!idx_ok) begin
            status = ST_BAD_INDEX;
        end

        o_rcv  = i_rcv;
        o_exp  = i_exp;
        o_hsrc = i_hsrc;
        o_pcnt = i_pcnt;
        done   = 1'b0;
        if (status == ST_OK) begin
            unique case (i_flit.kind)
                KIND_HEAD: begin
                    o_exp  = exp_wrap;
                    o_rcv  = 1'b1;
                    o_hsrc = src;
                end
                KIND_BODY: begin
                    o_exp = exp_wrap;
                end
                KIND_TAIL: begin
                    o_exp  = '0;
                    o_rcv  = 1'b0;
                    o_pcnt = i_pcnt + PKT_CNT_BITS'(1);
                    done   = 1'b1;
                end
                default: begin
                    if (i_cfg.flits_per_packet != FPP_BITS'(1)) begin
                        status = ST_SINGLE_WARN;
                    end
                    o_pcnt = i_pcnt + PKT_CNT_BITS'(1);
                    done   = 1'b1;
                end
            endcase
        end

        o_res.status       = status;
        o_res.packet_done  = done;
        o_res.done_packet  = done ? i_flit.packet_number : '0;
        o_res.done_src_x   = done ? i_flit.src_x : '0;
        o_res.done_src_y   = done ? i_flit.src_y : '0;
        o_res.done_src_z   = done ? i_flit.src_z : '0;
        o_res.recv_time    = done ? i_flit.now : '0;
        o_res.port_packets = o_pcnt;
    end

endmodule

`default_nettype wire

// ===== hdl/noc_flit_ejection_checker_unit.sv =====
// Top level of the flit ejection checker: request pipeline, per-port state RAM
// with write forwarding, config registers, output register.
// Depends on fec_pkg, fec_ram, fec_check.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready | i_in  (t_flit_in)
//  out     | output    | o_out_valid/i_out_ready | o_out (t_result)
//  cfg     | input     | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_wdata
//
// One request per cycle sustained while the output is not stalled; a request
// is registered with its state RAM read, then checked, written back and output.
// A write to the state RAM is forwarded to the request right behind it on the
// same port, so back-to-back flits on one port need no bubble.
// Synchronous reset; per-port valid bits make unwritten entries read as zero.
// A stalled output holds one result and one request in the RAM read stage.
`default_nettype none

module noc_flit_ejection_checker_unit
    import fec_pkg::*;
#(
    parameter int PORTS     = DEF_PORTS,
    parameter int MAX_FLITS = DEF_MAX_FLITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire t_flit_in                 i_in,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_result                       o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    localparam int AW = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int IW = $clog2(MAX_FLITS);
    localparam int WW = PKT_CNT_BITS + SRC_BITS + IW + 1;
    localparam int PB = $bits(i_in.port);
    localparam logic [PB+4:0] PORTS_V = (PB + 5)'(PORTS);

    t_cfg                r_cfg;
    logic                r_s1_valid;
    t_flit_in            r_s1_flit;
    logic [AW-1:0]       r_s1_addr;
    logic                r_s1_ent_vld;
    logic [PORTS-1:0]    r_vld;
    logic                r_fwd_valid;
    logic [AW-1:0]       r_fwd_addr;
    logic [WW-1:0]       r_fwd_data;
    logic                r_out_valid;
    t_result             r_out;

    logic                w_in_fire;
    logic                w_s1_adv;
    logic [PB-1:0]       w_port_red;
    logic [AW-1:0]       w_addr;
    logic [WW-1:0]       w_rdata;
    logic [WW-1:0]       w_cur;
    logic [WW-1:0]       w_next;
    t_result             w_res;
    logic                w_nrcv;
    logic [IW-1:0]       w_nexp;
    logic [SRC_BITS-1:0] w_nhsrc;
    logic [PKT_CNT_BITS-1:0] w_npcnt;

    // port reduced modulo PORTS by repeated subtraction on a narrow value
    always_comb begin
        w_port_red = i_in.port;
        for (int k = 0; k < (1 << PB); k++) begin
            if ({5'b0, w_port_red} >= PORTS_V) begin
                w_port_red = PB'({5'b0, w_port_red} - PORTS_V);
            end
        end
    end
    assign w_addr = AW'(w_port_red);

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_in_fire  = i_in_valid && o_in_ready;

    fec_ram #(
        .WIDTH (WW),
        .DEPTH (PORTS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (w_next),
        .i_re    (w_in_fire),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // newest write wins; never-written entries read as reset state
    assign w_cur = (r_fwd_valid && r_fwd_addr == r_s1_addr) ? r_fwd_data
                 : (r_s1_ent_vld ? w_rdata : '0);

    fec_check #(
        .MAX_FLITS (MAX_FLITS),
        .IW        (IW)
    ) u_check (
        .i_flit (r_s1_flit),
        .i_cfg  (r_cfg),
        .i_rcv  (w_cur[0]),
        .i_exp  (w_cur[IW:1]),
        .i_hsrc (w_cur[IW+SRC_BITS:IW+1]),
        .i_pcnt (w_cur[WW-1:IW+SRC_BITS+1]),
        .o_res  (w_res),
        .o_rcv  (w_nrcv),
        .o_exp  (w_nexp),
        .o_hsrc (w_nhsrc),
        .o_pcnt (w_npcnt)
    );

    assign w_next = {w_npcnt, w_nhsrc, w_nexp, w_nrcv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_x           <= '0;
            r_cfg.node_y           <= '0;
            r_cfg.node_z           <= '0;
            r_cfg.flits_per_packet <= FPP_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_X: r_cfg.node_x <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_NODE_Y: r_cfg.node_y <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_NODE_Z: r_cfg.node_z <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_FPP:    r_cfg.flits_per_packet <= i_cfg_wdata[FPP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_vld       <= '0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_vld[r_s1_addr] <= 1'b1;
                r_fwd_valid      <= 1'b1;
                r_out_valid      <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_flit    <= i_in;
            r_s1_addr    <= w_addr;
            r_s1_ent_vld <= r_vld[w_addr];
        end
        if (w_s1_adv) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= w_next;
            r_out      <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
